// ===== src/has160_pkg.sv =====
// package for the has-160 hash engine: payload types, constants, tables
package has160_pkg;

    localparam int BLOCK_BYTES_DEF = 64;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_valid;
        logic       end_of_message;
    } has160_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } has160_out_t;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // message word index for each of the eighty steps
    function automatic logic [4:0] word_order(input logic [6:0] i);
        logic [4:0] t [0:79];
        t = '{5'd18, 5'd0, 5'd1, 5'd2, 5'd3, 5'd19, 5'd4, 5'd5, 5'd6, 5'd7,
              5'd16, 5'd8, 5'd9, 5'd10, 5'd11, 5'd17, 5'd12, 5'd13, 5'd14, 5'd15,
              5'd22, 5'd3, 5'd6, 5'd9, 5'd12, 5'd23, 5'd15, 5'd2, 5'd5, 5'd8,
              5'd20, 5'd11, 5'd14, 5'd1, 5'd4, 5'd21, 5'd7, 5'd10, 5'd13, 5'd0,
              5'd26, 5'd12, 5'd5, 5'd14, 5'd7, 5'd27, 5'd0, 5'd9, 5'd2, 5'd11,
              5'd24, 5'd4, 5'd13, 5'd6, 5'd15, 5'd25, 5'd8, 5'd1, 5'd10, 5'd3,
              5'd30, 5'd7, 5'd2, 5'd13, 5'd8, 5'd31, 5'd3, 5'd14, 5'd9, 5'd4,
              5'd28, 5'd15, 5'd10, 5'd5, 5'd0, 5'd29, 5'd11, 5'd6, 5'd1, 5'd12};
        return (i < 7'd80) ? t[i] : 5'd0;
    endfunction

    function automatic logic [4:0] a_shift(input logic [4:0] j);
        logic [4:0] t [0:19];
        t = '{5'd5, 5'd11, 5'd7, 5'd15, 5'd6, 5'd13, 5'd8, 5'd14, 5'd7, 5'd12,
              5'd9, 5'd11, 5'd8, 5'd15, 5'd6, 5'd12, 5'd9, 5'd14, 5'd5, 5'd13};
        return (j < 5'd20) ? t[j] : 5'd0;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        return (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    // expansion sources, four 4-bit word indexes packed per expanded word
    function automatic logic [15:0] expand_src(input logic [3:0] k);
        logic [15:0] t [0:15];
        t = '{16'h0123, 16'h4567, 16'h89ab, 16'hcdef,
              16'h369c, 16'h258f, 16'h14be, 16'h07ad,
              16'h57ce, 16'h029b, 16'h46df, 16'h138a,
              16'h278d, 16'h349e, 16'h05af, 16'h16bc};
        return t[k];
    endfunction

endpackage

// ===== src/has160_hash_engine.sv =====
// has-160 hash engine top level: byte collector, padder and iterative compressor
//
//  channel | signals            | direction | payload
//  in      | in_valid, in_stall | to block  | has160_pkg::has160_in_t
//  out     | out_valid,out_stall| from block| has160_pkg::has160_out_t
//
// a block compression runs a read slot, the byte loads, the expansion, the round steps
// (one shared step unit) and a chaining add, in that order
// a final item adds one or two pad sweeps (one byte a cycle to the block end, the
// first from the marker), up to two compressions, then five digest transfers
// in_stall is high whenever the sequencer is not idle; reset is asynchronous
// and restores the initial chaining words and a zero byte count
// the digest register holds its word while out_stall is high
module has160_hash_engine #(
    parameter int BLOCK_BYTES = has160_pkg::BLOCK_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  has160_pkg::has160_in_t in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output has160_pkg::has160_out_t out_data
);
    import has160_pkg::*;

    localparam int AW = $clog2(BLOCK_BYTES);
    localparam int WN = BLOCK_BYTES / 4;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOADW = 4'd1;  // read block bytes from memory into words
    localparam logic [3:0] S_EXP   = 4'd2;  // build expanded words
    localparam logic [3:0] S_RND   = 4'd3;  // eighty steps
    localparam logic [3:0] S_ADD   = 4'd4;  // chaining add
    localparam logic [3:0] S_PAD   = 4'd5;  // write pad/zero/length bytes
    localparam logic [3:0] S_OUT   = 4'd6;  // digest transfers
    localparam logic [3:0] S_RDW   = 4'd7;  // read latency slot

    logic [3:0]  state_reg, state_next;
    logic [63:0] count_reg;
    logic [31:0] h_reg [0:4];
    logic [31:0] w_reg [0:31];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]  step_reg;
    logic        final_reg;      // compressing as part of message end
    logic        second_reg;     // padding needs a second block
    logic [AW:0] padpos_reg;
    logic [2:0]  onum_reg;
    logic        ovalid_reg;
    logic        mark_first_reg; // next pad write is the 0x80 marker

    // block memory, byte wide
    logic [7:0]    mem [0:BLOCK_BYTES-1];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [AW-1:0] mem_ra;
    logic [7:0]    mem_rd_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg <= mem[mem_ra];
    end

    wire in_xfer  = in_valid && !in_stall;
    wire out_xfer = ovalid_reg && !out_stall;
    wire [AW-1:0] pos = count_reg[AW-1:0];
    wire [63:0] bits = {count_reg[60:0], 3'b000};
    // marker position: after the byte of this transfer, if it carries one
    wire [AW-1:0] mark_pos = in_data.byte_valid ? AW'(pos + 1'b1) : pos;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data.digest_word = h_reg[onum_reg];
    assign out_data.word_number = onum_reg;
    assign out_data.last_word   = (onum_reg == 3'd4);

    // load counter: byte address issued is step_reg, data lands in the next cycle
    wire [AW:0]   ld_cnt  = step_reg[AW:0];
    wire [AW-1:0] ld_byte = AW'(ld_cnt - 1'b1);

    // padding byte value at padpos
    logic [7:0] pad_val;
    always_comb
    begin
        pad_val = 8'd0;
        if (mark_first_reg)
        begin
            pad_val = PAD_BYTE;
        end
        else if (padpos_reg >= (AW+1)'(BLOCK_BYTES - 8))
        begin
            if (!second_reg)
            begin
                pad_val = bits[8*(padpos_reg[2:0]) +: 8];
            end
        end
    end

    // one step of the round unit
    logic [1:0]  rnd;
    logic [4:0]  jj;
    logic [31:0] f, k, bsh, enew;
    logic [4:0]  bs;
    always_comb
    begin
        if (step_reg < 7'd20)
        begin
            rnd = 2'd0;
            jj  = step_reg[4:0];
        end
        else if (step_reg < 7'd40)
        begin
            rnd = 2'd1;
            jj  = 5'(step_reg - 7'd20);
        end
        else if (step_reg < 7'd60)
        begin
            rnd = 2'd2;
            jj  = 5'(step_reg - 7'd40);
        end
        else
        begin
            rnd = 2'd3;
            jj  = 5'(step_reg - 7'd60);
        end
        case (rnd)
            2'd0:
            begin
                f = d_reg ^ (b_reg & (c_reg ^ d_reg)); k = 32'h0;        bs = 5'd10;
            end
            2'd1:
            begin
                f = b_reg ^ c_reg ^ d_reg;             k = 32'h5A827999; bs = 5'd17;
            end
            2'd2:
            begin
                f = c_reg ^ (b_reg | ~d_reg);          k = 32'h6ED9EBA1; bs = 5'd25;
            end
            default:
            begin
                f = b_reg ^ c_reg ^ d_reg;             k = 32'h8F1BBCDC; bs = 5'd30;
            end
        endcase
        bsh  = rotl(b_reg, bs);
        enew = e_reg + rotl(a_reg, a_shift(jj)) + f + w_reg[word_order(step_reg)] + k;
    end

    logic [15:0] src;
    assign src = expand_src(step_reg[3:0]);

    always_comb
    begin
        state_next = state_reg;
        mem_we = 1'b0;
        mem_wa = pos;
        mem_wd = in_data.msg_byte;
        mem_ra = step_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && in_data.byte_valid)
                begin
                    mem_we = 1'b1;
                end
            end
            S_PAD:
            begin
                mem_we = 1'b1;
                mem_wa = padpos_reg[AW-1:0];
                mem_wd = pad_val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            h_reg          <= '{IV0, IV1, IV2, IV3, IV4};
            step_reg       <= '0;
            final_reg      <= 1'b0;
            second_reg     <= 1'b0;
            padpos_reg     <= '0;
            onum_reg       <= '0;
            ovalid_reg     <= 1'b0;
            mark_first_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (in_data.byte_valid)
                        begin
                            count_reg <= count_reg + 64'd1;
                        end
                        step_reg  <= '0;
                        final_reg <= in_data.end_of_message;
                        if (in_data.byte_valid && pos == AW'(BLOCK_BYTES - 1))
                        begin
                            state_reg <= S_RDW;
                            // byte with end fills the block: marker opens a fresh one
                            if (in_data.end_of_message)
                            begin
                                second_reg     <= 1'b0;
                                padpos_reg     <= '0;
                                mark_first_reg <= 1'b1;
                            end
                        end
                        else if (in_data.end_of_message)
                        begin
                            state_reg      <= S_PAD;
                            // no room for the length after the marker: two blocks
                            second_reg     <= (mark_pos >= AW'(BLOCK_BYTES - 8));
                            // pad marker goes at the next free byte
                            padpos_reg     <= {1'b0, mark_pos};
                            mark_first_reg <= 1'b1;
                        end
                    end
                end
                S_PAD:
                begin
                    // the first write is the 0x80 marker when mark_first_reg is set
                    padpos_reg     <= padpos_reg + 1'b1;
                    mark_first_reg <= 1'b0;
                    if (padpos_reg == (AW+1)'(BLOCK_BYTES - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= S_RDW;
                    end
                end
                S_RDW:
                begin
                    step_reg  <= step_reg + 7'd1;
                    state_reg <= S_LOADW;
                end
                S_LOADW:
                begin
                    w_reg[{1'b0, ld_byte[AW-1:2]}][8*ld_byte[1:0] +: 8] <= mem_rd_reg;
                    step_reg <= step_reg + 7'd1;
                    if (ld_cnt == (AW+1)'(BLOCK_BYTES))
                    begin
                        step_reg  <= '0;
                        state_reg <= S_EXP;
                    end
                end
                S_EXP:
                begin
                    w_reg[5'(WN) + 5'(step_reg[3:0])] <= w_reg[{1'b0, src[15:12]}] ^
                        w_reg[{1'b0, src[11:8]}] ^ w_reg[{1'b0, src[7:4]}] ^
                        w_reg[{1'b0, src[3:0]}];
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'd15)
                    begin
                        step_reg  <= '0;
                        a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                        d_reg <= h_reg[3]; e_reg <= h_reg[4];
                        state_reg <= S_RND;
                    end
                end
                S_RND:
                begin
                    a_reg <= enew; b_reg <= a_reg; c_reg <= bsh;
                    d_reg <= c_reg; e_reg <= d_reg;
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'd79)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    step_reg <= '0;
                    if (!final_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (mark_first_reg)
                    begin
                        // block came from a full byte with end: pad from zero
                        state_reg  <= S_PAD;
                        second_reg <= 1'b0;
                        padpos_reg <= '0;
                    end
                    else if (second_reg)
                    begin
                        second_reg <= 1'b0;
                        padpos_reg <= '0;
                        state_reg  <= S_PAD;
                    end
                    else
                    begin
                        onum_reg   <= '0;
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_xfer)
                    begin
                        onum_reg <= onum_reg + 3'd1;
                        if (onum_reg == 3'd4)
                        begin
                            ovalid_reg <= 1'b0;
                            h_reg      <= '{IV0, IV1, IV2, IV3, IV4};
                            count_reg  <= '0;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== tb/has160_hash_engine_test.sv =====
// testbench for the has-160 hash engine: table-driven and random messages checked against a predictor
`timescale 1ns / 1ps

module has160_hash_engine_test;
    import has160_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    has160_in_t  in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    has160_out_t out_data;

    has160_hash_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    // predictor state
    logic [31:0] hash_chain [0:4];
    logic [7:0]  hash_block [0:63];
    logic [63:0] hash_len;
    has160_out_t digest_queue [$];
    int          fail_count = 0;
    bit          stim_done = 1'b0;
    bit          hold_off = 1'b0;

    // digest of the empty message
    localparam logic [31:0] EMPTY_DIGEST [0:4] = '{
        32'hef647930, 32'h371d1534, 32'hde7a04c8, 32'hf450abc7, 32'h2d7689ff};

    // directed rows: table of items, expected digest typed in for the empty message
    typedef struct {
        logic [7:0]  b;
        logic        v;
        logic        e;
    } dir_row_t;

    localparam int DIR_ROWS = 12;
    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{8'h00, 1'b0, 1'b1},    // empty message right after reset
        '{8'hff, 1'b0, 1'b0},    // empty item, byte ignored
        '{8'h00, 1'b1, 1'b0},    // lowest byte
        '{8'hff, 1'b1, 1'b0},    // highest byte
        '{8'h61, 1'b1, 1'b1},    // byte with end
        '{8'hff, 1'b0, 1'b1},    // end marker only, ignored byte set
        '{8'h55, 1'b0, 1'b0},
        '{8'haa, 1'b1, 1'b0},
        '{8'h55, 1'b1, 1'b0},
        '{8'h0f, 1'b0, 1'b0},
        '{8'hf0, 1'b1, 1'b0},
        '{8'h00, 1'b0, 1'b1}
    };

    function automatic logic [31:0] rot(input logic [31:0] x, input int n);
        return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
    endfunction

    task automatic hash_compress();
        logic [31:0] w [0:31];
        logic [31:0] a, b, c, d, e, f, t;
        int r;
        int src [0:15][0:3] = '{
            '{0,1,2,3}, '{4,5,6,7}, '{8,9,10,11}, '{12,13,14,15},
            '{3,6,9,12}, '{2,5,8,15}, '{1,4,11,14}, '{0,7,10,13},
            '{5,7,12,14}, '{0,2,9,11}, '{4,6,13,15}, '{1,3,8,10},
            '{2,7,8,13}, '{3,4,9,14}, '{0,5,10,15}, '{1,6,11,12}};
        int ord [0:79] = '{
            18,0,1,2,3,19,4,5,6,7,16,8,9,10,11,17,12,13,14,15,
            22,3,6,9,12,23,15,2,5,8,20,11,14,1,4,21,7,10,13,0,
            26,12,5,14,7,27,0,9,2,11,24,4,13,6,15,25,8,1,10,3,
            30,7,2,13,8,31,3,14,9,4,28,15,10,5,0,29,11,6,1,12};
        int sa [0:19] = '{5,11,7,15,6,13,8,14,7,12,9,11,8,15,6,12,9,14,5,13};
        int sb [0:3] = '{10,17,25,30};
        logic [31:0] kr [0:3] = '{32'h0, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC};
        for (int i = 0; i < 16; i++)
            w[i] = {hash_block[4*i+3], hash_block[4*i+2], hash_block[4*i+1], hash_block[4*i]};
        for (int i = 0; i < 16; i++)
            w[16+i] = w[src[i][0]] ^ w[src[i][1]] ^ w[src[i][2]] ^ w[src[i][3]];
        a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2];
        d = hash_chain[3]; e = hash_chain[4];
        for (int i = 0; i < 80; i++)
        begin
            r = i / 20;
            if (r == 0)
                f = d ^ (b & (c ^ d));
            else if (r == 2)
                f = c ^ (b | ~d);
            else
                f = b ^ c ^ d;
            e = e + rot(a, sa[i % 20]) + f + w[ord[i]] + kr[r];
            b = rot(b, sb[r]);
            t = e; e = d; d = c; c = b; b = a; a = t;
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c;
        hash_chain[3] += d; hash_chain[4] += e;
    endtask

    task automatic hash_restart();
        hash_chain = '{IV0, IV1, IV2, IV3, IV4};
        hash_len = '0;
    endtask

    // advance the predictor by one accepted item, queue any digest words
    task automatic hash_item(input has160_in_t it);
        int pos;
        logic [63:0] bits;
        has160_out_t r;
        if (it.byte_valid)
        begin
            pos = int'(hash_len[5:0]);
            hash_block[pos] = it.msg_byte;
            hash_len++;
            if (pos == 63)
                hash_compress();
        end
        if (!it.end_of_message)
            return;
        bits = hash_len << 3;
        pos = int'(hash_len[5:0]);
        hash_block[pos] = PAD_BYTE;
        pos++;
        if (pos > 56)
        begin
            for (int i = pos; i < 64; i++)
                hash_block[i] = 8'h00;
            hash_compress();
            pos = 0;
        end
        for (int i = pos; i < 56; i++)
            hash_block[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            hash_block[56+i] = bits[8*i +: 8];
        hash_compress();
        for (int i = 0; i < 5; i++)
        begin
            r.digest_word = hash_chain[i];
            r.word_number = 3'(i);
            r.last_word = (i == 4);
            digest_queue.push_back(r);
        end
        hash_restart();
    endtask

    // one transfer on the input channel, after a random gap
    task automatic send_item(input has160_in_t it);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        hash_item(it);
        @(negedge clk);
    endtask

    task automatic send_msg(input int len);
        has160_in_t it;
        for (int i = 0; i < len; i++)
        begin
            it.msg_byte = 8'($urandom);
            it.byte_valid = 1'b1;
            it.end_of_message = (i == len - 1);
            if ($urandom_range(0, 15) == 0)
            begin
                it.byte_valid = 1'b0;
                it.end_of_message = 1'b0;
                send_item(it);
                it.byte_valid = 1'b1;
                it.end_of_message = (i == len - 1);
            end
            send_item(it);
        end
    endtask

    // stimulus
    initial
    begin
        has160_in_t it;
        int sent;
        int lens [0:1] = '{56, 64};
        hash_restart();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // directed rows; the empty message digest is typed in
        for (int k = 0; k < DIR_ROWS; k++)
        begin
            it.msg_byte = dir_tab[k].b;
            it.byte_valid = dir_tab[k].v;
            it.end_of_message = dir_tab[k].e;
            send_item(it);
            if (k == 0)
            begin
                // known digest of the empty message
                for (int i = 0; i < 5; i++)
                begin
                    if (digest_queue[i].digest_word !== EMPTY_DIGEST[i])
                    begin
                        $error("digest_word expected %h actual %h", EMPTY_DIGEST[i],
                               digest_queue[i].digest_word);
                        fail_count++;
                    end
                end
            end
        end
        // padding boundaries, with a long receiver hold-off during the first
        hold_off = 1'b1;
        foreach (lens[k])
            send_msg(lens[k]);
        // random messages, mostly short
        sent = 0;
        while (sent < 100)
        begin
            int len;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 70)
                                              : $urandom_range(0, 20);
            if (len > 100 - sent)
                len = 100 - sent;
            if (len == 0)
            begin
                it.msg_byte = 8'($urandom);
                it.byte_valid = 1'b0;
                it.end_of_message = 1'b1;
                send_item(it);
                sent++;
            end
            else
            begin
                send_msg(len);
                sent += len;
            end
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver stall pattern: one long hold-off, then random gaps
    initial
    begin
        int gap;
        wait (hold_off);
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (1500) @(negedge clk);
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 3) == 0)
                continue;
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // compare each digest transfer with the oldest expected word
    always @(posedge clk)
    begin
        has160_out_t x;
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_queue.size() == 0)
            begin
                $error("unexpected digest word %h", out_data.digest_word);
                fail_count++;
            end
            else
            begin
                x = digest_queue.pop_front();
                if (out_data.digest_word !== x.digest_word)
                begin
                    $error("digest_word expected %h actual %h", x.digest_word,
                           out_data.digest_word);
                    fail_count++;
                end
                if (out_data.word_number !== x.word_number)
                begin
                    $error("word_number expected %0d actual %0d", x.word_number,
                           out_data.word_number);
                    fail_count++;
                end
                if (out_data.last_word !== x.last_word)
                begin
                    $error("last_word expected %0d actual %0d", x.last_word,
                           out_data.last_word);
                    fail_count++;
                end
            end
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        wait (digest_queue.size() == 0);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
